// ===== hdl/scpac_pkg.sv =====
// shared types, codes and constants of the smart-card pin access control unit
// no dependencies
`default_nettype none

package scpac_pkg;

  localparam int PinBytesDefault = 8;
  localparam int QueueDepth      = 2;

  localparam logic [1:0] TriesMax = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_USER_PIN     = 2'd0;
  localparam logic [1:0] CFG_USER_PIN_LEN = 2'd1;
  localparam logic [1:0] CFG_ADMIN_PIN    = 2'd2;
  localparam logic [1:0] CFG_ADMIN_PIN_LEN = 2'd3;

  localparam logic [63:0] UserPinReset     = 64'h3132333435360000;
  localparam logic [3:0]  UserPinLenReset  = 4'd6;
  localparam logic [63:0] AdminPinReset    = 64'h3132333435363738;
  localparam logic [3:0]  AdminPinLenReset = 4'd8;

  localparam logic [47:0] AidPrefix = 48'hD27600012401;

  localparam logic [7:0] INS_SELECT = 8'hA4;
  localparam logic [7:0] INS_VERIFY = 8'h20;
  localparam logic [7:0] INS_GET    = 8'hCA;
  localparam logic [7:0] INS_PUT    = 8'hDA;
  localparam logic [7:0] INS_SIGN   = 8'h2A;

  localparam logic [7:0] P1_SELECT_AID = 8'h04;
  localparam logic [7:0] P2_PIN_SIGN   = 8'h81;
  localparam logic [7:0] P2_PIN_USER   = 8'h82;
  localparam logic [7:0] P2_PIN_ADMIN  = 8'h83;
  localparam logic [7:0] P1_SIGN       = 8'h9E;
  localparam logic [7:0] P2_SIGN       = 8'h9A;

  typedef enum logic [3:0] {
    ST_OK          = 4'd0,
    ST_LENGTH      = 4'd1,
    ST_NOT_FOUND   = 4'd2,
    ST_CONDITIONS  = 4'd3,
    ST_P1P2        = 4'd4,
    ST_BLOCKED     = 4'd5,
    ST_RETRIES     = 4'd6,
    ST_SECURITY    = 4'd7,
    ST_UNSUPPORTED = 4'd8
  } status_e;

  typedef enum logic [1:0] {
    FWD_NONE = 2'd0,
    FWD_GET  = 2'd1,
    FWD_PUT  = 2'd2,
    FWD_SIGN = 2'd3
  } fwd_e;

  typedef enum logic [3:0] {
    CMD_LENGTH,
    CMD_SEL_FAIL,
    CMD_SELECT,
    CMD_VERIFY_BADP2,
    CMD_VERIFY,
    CMD_GET,
    CMD_PUT,
    CMD_SIGN_BADP1P2,
    CMD_SIGN,
    CMD_UNSUPPORTED
  } cmd_kind_e;

  typedef enum logic [1:0] {
    PIN_SIGN,
    PIN_USER,
    PIN_ADMIN
  } pin_sel_e;

  // classified request handed from front to back
  typedef struct packed {
    cmd_kind_e kind;
    pin_sel_e  pin;
    logic      lc_zero;
    logic      pin_good;
  } cmd_t;

  typedef struct packed {
    status_e    status;
    logic [1:0] retries;
    fwd_e       forward;
  } res_t;

endpackage

`default_nettype wire

// ===== hdl/scpac_fifo.sv =====
// small synchronous queue used between front, back and the result port
// depends on nothing but its parameters
`default_nettype none

module scpac_fifo #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] wdata_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [Width-1:0]      rdata_o,
  output logic                  empty_o
);

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [AW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] count_q, count_d;
  logic          do_push, do_pop;

  assign full_o  = (count_q == CW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AW'(Depth - 1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(Depth - 1)) ? '0 : rd_ptr_q + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/scpac_front.sv =====
// front part: pin configuration registers and command classification
// depends on scpac_pkg
`default_nettype none

module scpac_front
  import scpac_pkg::*;
#(
  parameter int PinBytes = PinBytesDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [63:0] cfg_data_i,
  input  wire logic        length_ok_i,
  input  wire logic [7:0]  op_i,
  input  wire logic [7:0]  param_one_i,
  input  wire logic [7:0]  param_two_i,
  input  wire logic [15:0] data_length_i,
  input  wire logic [63:0] data_head_i,
  output cmd_t             cmd_o
);

  logic [63:0] user_pin_q, admin_pin_q;
  logic [3:0]  user_len_q, admin_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      user_pin_q  <= UserPinReset;
      user_len_q  <= UserPinLenReset;
      admin_pin_q <= AdminPinReset;
      admin_len_q <= AdminPinLenReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_USER_PIN:      user_pin_q  <= cfg_data_i;
        CFG_USER_PIN_LEN:  user_len_q  <= cfg_data_i[3:0];
        CFG_ADMIN_PIN:     admin_pin_q <= cfg_data_i;
        CFG_ADMIN_PIN_LEN: admin_len_q <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  logic        is_user, is_admin;
  logic [63:0] sel_pin;
  logic [3:0]  sel_len;
  logic        bytes_eq;

  assign is_user  = (param_two_i == P2_PIN_SIGN) || (param_two_i == P2_PIN_USER);
  assign is_admin = (param_two_i == P2_PIN_ADMIN);
  assign sel_pin  = is_admin ? admin_pin_q : user_pin_q;
  assign sel_len  = is_admin ? admin_len_q : user_len_q;

  // leading bytes up to the pin length must match
  always_comb begin
    bytes_eq = 1'b1;
    for (int k = 0; k < 8; k++) begin
      if ((4'(k) < sel_len) &&
          (data_head_i[63-8*k -: 8] != sel_pin[63-8*k -: 8])) begin
        bytes_eq = 1'b0;
      end
    end
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.kind     = CMD_UNSUPPORTED;
    cmd_o.pin      = is_admin ? PIN_ADMIN :
                     ((param_two_i == P2_PIN_SIGN) ? PIN_SIGN : PIN_USER);
    cmd_o.lc_zero  = (data_length_i == '0);
    cmd_o.pin_good = bytes_eq && (sel_len != '0) && (sel_len <= 4'(PinBytes)) &&
                     (data_length_i == {12'd0, sel_len});
    if (!length_ok_i) begin
      cmd_o.kind = CMD_LENGTH;
    end else begin
      case (op_i)
        INS_SELECT: begin
          if (param_one_i != P1_SELECT_AID || data_length_i < 16'd6 ||
              data_head_i[63:16] != AidPrefix) begin
            cmd_o.kind = CMD_SEL_FAIL;
          end else begin
            cmd_o.kind = CMD_SELECT;
          end
        end
        INS_VERIFY: cmd_o.kind = (is_user || is_admin) ? CMD_VERIFY : CMD_VERIFY_BADP2;
        INS_GET:    cmd_o.kind = CMD_GET;
        INS_PUT:    cmd_o.kind = CMD_PUT;
        INS_SIGN: begin
          if (param_one_i != P1_SIGN || param_two_i != P2_SIGN) begin
            cmd_o.kind = CMD_SIGN_BADP1P2;
          end else begin
            cmd_o.kind = CMD_SIGN;
          end
        end
        default: cmd_o.kind = CMD_UNSUPPORTED;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hdl/scpac_back.sv =====
// back part: selection, verified flags, retry counters and result codes
// depends on scpac_pkg
`default_nettype none

module scpac_back
  import scpac_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire cmd_t cmd_i,
  input  wire logic cmd_valid_i,
  output logic      cmd_pop_o,
  input  wire logic res_full_i,
  output logic      res_push_o,
  output res_t      res_o
);

  logic       selected_q, selected_d;
  logic       sign_ok_q, sign_ok_d;
  logic       user_ok_q, user_ok_d;
  logic       admin_ok_q, admin_ok_d;
  logic [1:0] user_tries_q, user_tries_d;
  logic [1:0] admin_tries_q, admin_tries_d;
  logic [1:0] tries, tries_next;
  logic       fire;

  assign fire       = cmd_valid_i && !res_full_i;
  assign cmd_pop_o  = fire;
  assign res_push_o = fire;

  assign tries = (cmd_i.pin == PIN_ADMIN) ? admin_tries_q : user_tries_q;

  always_comb begin
    selected_d    = selected_q;
    sign_ok_d     = sign_ok_q;
    user_ok_d     = user_ok_q;
    admin_ok_d    = admin_ok_q;
    user_tries_d  = user_tries_q;
    admin_tries_d = admin_tries_q;
    tries_next    = tries;
    res_o         = '{status: ST_OK, retries: 2'd0, forward: FWD_NONE};

    case (cmd_i.kind)
      CMD_LENGTH:   res_o.status = ST_LENGTH;
      CMD_SEL_FAIL: res_o.status = ST_NOT_FOUND;
      CMD_SELECT: begin
        selected_d = 1'b1;
        sign_ok_d  = 1'b0;
        user_ok_d  = 1'b0;
        admin_ok_d = 1'b0;
      end
      default: begin
        if (!selected_q) begin
          res_o.status = ST_CONDITIONS;
        end else begin
          case (cmd_i.kind)
            CMD_VERIFY_BADP2: res_o.status = ST_P1P2;
            CMD_VERIFY: begin
              if (tries == 2'd0) begin
                res_o.status = ST_BLOCKED;
              end else if (cmd_i.lc_zero) begin
                res_o.status  = ST_RETRIES;
                res_o.retries = tries;
              end else if (!cmd_i.pin_good) begin
                tries_next    = tries - 2'd1;
                res_o.status  = ST_RETRIES;
                res_o.retries = tries_next;
              end else begin
                tries_next = TriesMax;
                case (cmd_i.pin)
                  PIN_SIGN:  sign_ok_d  = 1'b1;
                  PIN_USER:  user_ok_d  = 1'b1;
                  PIN_ADMIN: admin_ok_d = 1'b1;
                  default: ;
                endcase
              end
              if (cmd_i.pin == PIN_ADMIN) begin
                admin_tries_d = tries_next;
              end else begin
                user_tries_d = tries_next;
              end
            end
            CMD_GET: res_o.forward = FWD_GET;
            CMD_PUT: begin
              if (!admin_ok_q) begin
                res_o.status = ST_SECURITY;
              end else begin
                res_o.forward = FWD_PUT;
              end
            end
            CMD_SIGN_BADP1P2: res_o.status = ST_P1P2;
            CMD_SIGN: begin
              if (!sign_ok_q) begin
                res_o.status = ST_SECURITY;
              end else begin
                res_o.forward = FWD_SIGN;
              end
            end
            default: res_o.status = ST_UNSUPPORTED;
          endcase
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      selected_q    <= 1'b0;
      sign_ok_q     <= 1'b0;
      user_ok_q     <= 1'b0;
      admin_ok_q    <= 1'b0;
      user_tries_q  <= TriesMax;
      admin_tries_q <= TriesMax;
    end else if (fire) begin
      selected_q    <= selected_d;
      sign_ok_q     <= sign_ok_d;
      user_ok_q     <= user_ok_d;
      admin_ok_q    <= admin_ok_d;
      user_tries_q  <= user_tries_d;
      admin_tries_q <= admin_tries_d;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/smartcard_pin_access_control_unit.sv =====
// top level of the smart-card pin access control unit
// depends on scpac_pkg, scpac_front, scpac_back and scpac_fifo
`default_nettype none

// Gate for parsed smart-card commands in the style of an OpenPGP card. Each
// request (INS, P1, P2, Lc, first eight data bytes) yields one result: a status
// code, the retry count of the addressed PIN and a forward code for get data,
// put data or sign requests that passed their access checks. The unit takes
// one request per clock while full is low and delivers one result per clock
// while results are popped. The front compares the PIN and classifies the
// request combinationally and writes it into a two-entry queue; the back pops
// it, updates selection, verified flags and retry counters and writes the
// result into a two-entry output queue that drives the result ports, so
// either side may stall without stopping the other. PIN registers are
// written through the configuration port, which is always ready; write them
// only when no request is in flight. Register index 0 user PIN, 1 user PIN
// length, 2 admin PIN, 3 admin PIN length.
module smartcard_pin_access_control_unit
  import scpac_pkg::*;
#(
  parameter int PinBytes = PinBytesDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration write channel
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [63:0] cfg_data_i,
  // request side
  input  wire logic        push,
  output logic             full,
  input  wire logic        length_ok_i,
  input  wire logic [7:0]  op_i,
  input  wire logic [7:0]  param_one_i,
  input  wire logic [7:0]  param_two_i,
  input  wire logic [15:0] data_length_i,
  input  wire logic [63:0] data_head_i,
  // result side
  output logic             empty,
  input  wire logic        pop,
  output logic [3:0]       status_o,
  output logic [1:0]       retries_o,
  output logic [1:0]       forward_o
);

  localparam int CmdW = $bits(cmd_t);
  localparam int ResW = $bits(res_t);

  cmd_t cmd_in, cmd_out;
  res_t res_in, res_out;
  logic cmd_empty, cmd_pop;
  logic res_full, res_push;

  // config is never back-pressured
  assign cfg_ready_o = 1'b1;

  scpac_front #(
    .PinBytes(PinBytes)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .length_ok_i   (length_ok_i),
    .op_i          (op_i),
    .param_one_i   (param_one_i),
    .param_two_i   (param_two_i),
    .data_length_i (data_length_i),
    .data_head_i   (data_head_i),
    .cmd_o         (cmd_in)
  );

  // classified requests waiting for the back
  scpac_fifo #(
    .Width(CmdW),
    .Depth(QueueDepth)
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (cmd_in),
    .full_o  (full),
    .pop_i   (cmd_pop),
    .rdata_o (cmd_out),
    .empty_o (cmd_empty)
  );

  scpac_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_out),
    .cmd_valid_i (!cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  // finished results waiting to be taken
  scpac_fifo #(
    .Width(ResW),
    .Depth(QueueDepth)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (res_out),
    .empty_o (empty)
  );

  assign status_o  = res_out.status;
  assign retries_o = res_out.retries;
  assign forward_o = res_out.forward;

endmodule

`default_nettype wire

// ===== test/smartcard_pin_access_control_unit_tb.sv =====
// self-checking testbench for the smart-card pin access control unit
// depends on scpac_pkg and smartcard_pin_access_control_unit, needs nothing else

module smartcard_pin_access_control_unit_tb;
  import scpac_pkg::*;

  localparam int unsigned CycleLimit = 100000;
  localparam int unsigned MaxReports = 10;

  // one parsed card command as the sender sees it
  typedef struct packed {
    logic        length_ok;
    logic [7:0]  ins;
    logic [7:0]  p1;
    logic [7:0]  p2;
    logic [15:0] lc;
    logic [63:0] data;
  } apdu_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = CFG_USER_PIN;
  logic [63:0] cfg_data_i = '0;
  logic        push = 1'b0;
  logic        full;
  logic        length_ok_i = 1'b0;
  logic [7:0]  op_i = '0;
  logic [7:0]  param_one_i = '0;
  logic [7:0]  param_two_i = '0;
  logic [15:0] data_length_i = '0;
  logic [63:0] data_head_i = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [3:0]  status_o;
  logic [1:0]  retries_o;
  logic [1:0]  forward_o;

  // answers predicted for accepted requests, oldest first
  res_t expected_answers[$];

  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned send_gap_pct = 10;
  int unsigned pop_stall_pct = 45;

  // shadow of the pin registers
  logic [63:0] cur_user_pin = UserPinReset;
  logic [3:0]  cur_user_len = UserPinLenReset;
  logic [63:0] cur_admin_pin = AdminPinReset;
  logic [3:0]  cur_admin_len = AdminPinLenReset;

  // shadow of the card state
  logic       applet_on = 1'b0;
  logic       sign_verified = 1'b0;
  logic       user_verified = 1'b0;
  logic       admin_verified = 1'b0;
  logic [1:0] user_tries = TriesMax;
  logic [1:0] admin_tries = TriesMax;

  smartcard_pin_access_control_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .push         (push),
    .full         (full),
    .length_ok_i  (length_ok_i),
    .op_i         (op_i),
    .param_one_i  (param_one_i),
    .param_two_i  (param_two_i),
    .data_length_i(data_length_i),
    .data_head_i  (data_head_i),
    .empty        (empty),
    .pop          (pop),
    .status_o     (status_o),
    .retries_o    (retries_o),
    .forward_o    (forward_o)
  );

  always #2 clk_i = ~clk_i;

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic log_failure(input string msg);
    error_count++;
    if (error_count <= MaxReports) $display("cycle %0d mismatch: %s", cycle_count, msg);
  endtask

  // true when len is 1 to 8 and the first len bytes of the data agree with the pin
  function automatic logic pin_fits(logic [63:0] data, logic [63:0] pin, logic [3:0] len);
    logic [63:0] mask;
    if (len == 4'd0 || int'(len) > PinBytesDefault) return 1'b0;
    mask = ~64'd0 << (64 - 8 * int'(len));
    return ((data ^ pin) & mask) == 64'd0;
  endfunction

  // answer of the card to one request, updating the shadow state
  function automatic res_t judge_command(apdu_t a);
    res_t r;
    logic is_user;
    logic is_admin;
    logic [1:0] t;
    logic [63:0] pin;
    logic [3:0] len;
    r.status = ST_OK;
    r.retries = 2'd0;
    r.forward = FWD_NONE;
    if (!a.length_ok) begin
      r.status = ST_LENGTH;
    end else if (a.ins == INS_SELECT) begin
      if (a.p1 != P1_SELECT_AID || a.lc < 16'd6 || a.data[63:16] != AidPrefix) begin
        r.status = ST_NOT_FOUND;
      end else begin
        // a good select drops every verified flag but keeps the counters
        applet_on = 1'b1;
        sign_verified = 1'b0;
        user_verified = 1'b0;
        admin_verified = 1'b0;
      end
    end else if (!applet_on) begin
      r.status = ST_CONDITIONS;
    end else begin
      case (a.ins)
        INS_VERIFY: begin
          // sign and user pin share one counter
          is_user = (a.p2 == P2_PIN_SIGN) || (a.p2 == P2_PIN_USER);
          is_admin = (a.p2 == P2_PIN_ADMIN);
          if (!is_user && !is_admin) begin
            r.status = ST_P1P2;
          end else begin
            t = is_user ? user_tries : admin_tries;
            pin = is_user ? cur_user_pin : cur_admin_pin;
            len = is_user ? cur_user_len : cur_admin_len;
            if (t == 2'd0) begin
              r.status = ST_BLOCKED;
            end else if (a.lc == 16'd0) begin
              r.status = ST_RETRIES;
              r.retries = t;
            end else if (a.lc != {12'd0, len} || !pin_fits(a.data, pin, len)) begin
              t = t - 2'd1;
              r.status = ST_RETRIES;
              r.retries = t;
            end else begin
              t = TriesMax;
              if (a.p2 == P2_PIN_SIGN) sign_verified = 1'b1;
              else if (a.p2 == P2_PIN_USER) user_verified = 1'b1;
              else admin_verified = 1'b1;
            end
            if (is_user) user_tries = t;
            else admin_tries = t;
          end
        end
        INS_GET: r.forward = FWD_GET;
        INS_PUT: begin
          if (admin_verified) r.forward = FWD_PUT;
          else r.status = ST_SECURITY;
        end
        INS_SIGN: begin
          if (a.p1 != P1_SIGN || a.p2 != P2_SIGN) r.status = ST_P1P2;
          else if (!sign_verified) r.status = ST_SECURITY;
          else r.forward = FWD_SIGN;
        end
        default: r.status = ST_UNSUPPORTED;
      endcase
    end
    return r;
  endfunction

  function automatic apdu_t mk(logic ok, logic [7:0] ins, logic [7:0] p1, logic [7:0] p2,
                               logic [15:0] lc, logic [63:0] data);
    apdu_t a;
    a.length_ok = ok;
    a.ins = ins;
    a.p1 = p1;
    a.p2 = p2;
    a.lc = lc;
    a.data = data;
    return a;
  endfunction

  // mostly well-formed command flows with random content, some noise
  function automatic apdu_t random_apdu();
    apdu_t a;
    int unsigned pick;
    int bitpos;
    logic is_admin;
    logic [63:0] pin;
    logic [63:0] mask;
    logic [3:0] len;
    logic [1:0] tries;
    a.length_ok = 1'b1;
    a.ins = INS_GET;
    a.p1 = 8'($urandom);
    a.p2 = 8'($urandom);
    a.lc = 16'($urandom);
    a.data = {$urandom, $urandom};
    pick = $urandom_range(99);
    if (pick < 10) begin
      // pure noise
      a.length_ok = 1'($urandom_range(1));
      a.ins = 8'($urandom);
    end else if (pick < 15) begin
      a.length_ok = 1'b0;
      a.ins = ($urandom_range(1) == 0) ? INS_SELECT : 8'($urandom);
    end else if (pick < 23) begin
      a.ins = INS_SELECT;
      a.p1 = P1_SELECT_AID;
      a.lc = 16'($urandom_range(6, 40));
      a.data = {AidPrefix, a.data[15:0]};
      case ($urandom_range(9))
        0: a.p1 = 8'($urandom);
        1: a.lc = 16'($urandom_range(5));
        2: begin
          bitpos = 16 + int'($urandom_range(47));
          a.data[bitpos] = ~a.data[bitpos];
        end
        default: ;
      endcase
    end else if (pick < 58) begin
      a.ins = INS_VERIFY;
      case ($urandom_range(2))
        0: a.p2 = P2_PIN_SIGN;
        1: a.p2 = P2_PIN_USER;
        default: a.p2 = P2_PIN_ADMIN;
      endcase
      if ($urandom_range(9) == 0) a.p2 = 8'($urandom);
      is_admin = (a.p2 == P2_PIN_ADMIN);
      pin = is_admin ? cur_admin_pin : cur_user_pin;
      len = is_admin ? cur_admin_len : cur_user_len;
      tries = is_admin ? admin_tries : user_tries;
      mask = ~64'd0 << (64 - 8 * int'(len));
      a.lc = {12'd0, len};
      a.data = (pin & mask) | (a.data & ~mask);
      if ($urandom_range(19) == 0) begin
        a.lc = 16'd0;
      end else if (tries != 2'd1 && $urandom_range(99) < 40) begin
        // wrong pin, but never the last try so the card stays usable
        if ($urandom_range(1) == 1 || len == 4'd0 || int'(len) > PinBytesDefault) begin
          a.lc = a.lc + 16'($urandom_range(1, 3));
        end else begin
          bitpos = 63 - int'($urandom_range(8 * int'(len) - 1));
          a.data[bitpos] = ~a.data[bitpos];
        end
      end
    end else if (pick < 68) begin
      a.ins = INS_GET;
    end else if (pick < 78) begin
      a.ins = INS_PUT;
    end else if (pick < 95) begin
      a.ins = INS_SIGN;
      a.p1 = P1_SIGN;
      a.p2 = P2_SIGN;
      if ($urandom_range(6) == 0) begin
        if ($urandom_range(1) == 1) a.p1 = 8'($urandom);
        else a.p2 = 8'($urandom);
      end
    end else begin
      do a.ins = 8'($urandom);
      while (a.ins == INS_SELECT || a.ins == INS_VERIFY || a.ins == INS_GET ||
             a.ins == INS_PUT || a.ins == INS_SIGN);
    end
    return a;
  endfunction

  // send one request, predicting its answer at the accepting edge
  task automatic issue_apdu(input apdu_t a);
    while ($urandom_range(99) < send_gap_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    length_ok_i <= a.length_ok;
    op_i <= a.ins;
    param_one_i <= a.p1;
    param_two_i <= a.p2;
    data_length_i <= a.lc;
    data_head_i <= a.data;
    do @(posedge clk_i);
    while (full);
    expected_answers.push_back(judge_command(a));
  endtask

  task automatic run_random(input int unsigned n);
    repeat (n) issue_apdu(random_apdu());
  endtask

  // stop sending and let every outstanding answer come back
  task automatic wait_idle();
    push <= 1'b0;
    while (expected_answers.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    case (idx)
      CFG_USER_PIN:     cur_user_pin = val;
      CFG_USER_PIN_LEN: cur_user_len = val[3:0];
      CFG_ADMIN_PIN:    cur_admin_pin = val;
      default:          cur_admin_len = val[3:0];
    endcase
  endtask

  task automatic load_pins(input logic [63:0] upin, input logic [3:0] ulen,
                           input logic [63:0] apin, input logic [3:0] alen);
    wait_idle();
    write_reg(CFG_USER_PIN, upin);
    write_reg(CFG_USER_PIN_LEN, {60'd0, ulen});
    write_reg(CFG_ADMIN_PIN, apin);
    write_reg(CFG_ADMIN_PIN_LEN, {60'd0, alen});
    cfg_valid_i <= 1'b0;
  endtask

  // every command path with the reset pins
  task automatic test_command_paths();
    logic [63:0] aid;
    aid = {AidPrefix, 16'h5A5A};
    // malformed requests answer wrong length whatever they hold
    issue_apdu(mk(1'b0, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, ~64'd0));
    issue_apdu(mk(1'b0, INS_SELECT, P1_SELECT_AID, 8'h00, 16'd6, aid));
    // nothing selected yet
    issue_apdu(mk(1'b1, INS_VERIFY, 8'h00, P2_PIN_USER, 16'd6, UserPinReset));
    issue_apdu(mk(1'b1, 8'h00, 8'h00, 8'h00, 16'd0, 64'd0));
    // failing selects: wrong p1, short lc, wrong prefix; then a good select
    issue_apdu(mk(1'b1, INS_SELECT, 8'h00, 8'h00, 16'd6, aid));
    issue_apdu(mk(1'b1, INS_SELECT, P1_SELECT_AID, 8'h00, 16'd5, aid));
    issue_apdu(mk(1'b1, INS_SELECT, P1_SELECT_AID, 8'h00, 16'd6, aid ^ (64'd1 << 63)));
    issue_apdu(mk(1'b1, INS_SELECT, P1_SELECT_AID, 8'hFF, 16'hFFFF, {AidPrefix, 16'hFFFF}));
    // verify: unknown p2, zero lc, wrong pin, lc mismatch, extra data bytes, sign pin
    issue_apdu(mk(1'b1, INS_VERIFY, 8'h00, 8'h84, 16'd6, UserPinReset));
    issue_apdu(mk(1'b1, INS_VERIFY, 8'h00, P2_PIN_USER, 16'd0, UserPinReset));
    issue_apdu(mk(1'b1, INS_VERIFY, 8'h00, P2_PIN_USER, 16'd6, 64'd0));
    issue_apdu(mk(1'b1, INS_VERIFY, 8'h00, P2_PIN_USER, 16'd7, UserPinReset));
    issue_apdu(mk(1'b1, INS_VERIFY, 8'h00, P2_PIN_USER, 16'd6, UserPinReset | 64'hBEEF));
    issue_apdu(mk(1'b1, INS_VERIFY, 8'h00, P2_PIN_SIGN, 16'd6, UserPinReset));
    // sign with bad p2, then a passing sign; put before and after admin verify, get, unknown ins
    issue_apdu(mk(1'b1, INS_SIGN, P1_SIGN, 8'h00, 16'd32, 64'd0));
    issue_apdu(mk(1'b1, INS_SIGN, P1_SIGN, P2_SIGN, 16'd32, 64'd0));
    issue_apdu(mk(1'b1, INS_PUT, 8'h00, 8'h6E, 16'd4, 64'd0));
    issue_apdu(mk(1'b1, INS_VERIFY, 8'h00, P2_PIN_ADMIN, 16'd8, AdminPinReset ^ 64'h01));
    issue_apdu(mk(1'b1, INS_VERIFY, 8'h00, P2_PIN_ADMIN, 16'd8, AdminPinReset));
    issue_apdu(mk(1'b1, INS_PUT, 8'hFF, 8'hFF, 16'hFFFF, ~64'd0));
    issue_apdu(mk(1'b1, INS_GET, 8'h00, 8'h00, 16'd0, 64'd0));
    issue_apdu(mk(1'b1, 8'hFF, 8'h00, 8'h00, 16'd0, 64'd0));
    // reselect clears the verified flags
    issue_apdu(mk(1'b1, INS_SELECT, P1_SELECT_AID, 8'h00, 16'd6, aid));
    issue_apdu(mk(1'b1, INS_SIGN, P1_SIGN, P2_SIGN, 16'd32, 64'd0));
    issue_apdu(mk(1'b1, INS_PUT, 8'h00, 8'h6E, 16'd4, 64'd0));
  endtask

  // shortest and longest pin lengths, all-ones admin pin
  task automatic test_length_extremes();
    load_pins({$urandom, $urandom}, 4'd1, ~64'd0, 4'd8);
    run_random(125);
  endtask

  // all-zero user pin, with one pause until the pipe is empty
  task automatic test_zero_pin_and_drain();
    load_pins(64'd0, 4'd8, {$urandom, $urandom}, 4'd1);
    run_random(60);
    wait_idle();
    run_random(65);
  endtask

  // slow sender, eager receiver
  task automatic test_slow_sender();
    send_gap_pct = 45;
    pop_stall_pct = 10;
    load_pins({$urandom, $urandom}, 4'($urandom_range(1, 8)),
              {$urandom, $urandom}, 4'($urandom_range(1, 8)));
    run_random(125);
  endtask

  // no idling on either side
  task automatic test_back_to_back();
    send_gap_pct = 0;
    pop_stall_pct = 0;
    load_pins({$urandom, $urandom}, 4'($urandom_range(1, 8)),
              {$urandom, $urandom}, 4'($urandom_range(1, 8)));
    run_random(125);
  endtask

  // pin lengths that can never match, so both counters run out and stay blocked
  task automatic test_lockout();
    logic [63:0] upin;
    logic [63:0] apin;
    upin = {$urandom, $urandom};
    apin = {$urandom, $urandom};
    load_pins(upin, 4'd0, apin, 4'd15);
    issue_apdu(mk(1'b1, INS_SELECT, P1_SELECT_AID, 8'h00, 16'd6, {AidPrefix, 16'h0000}));
    issue_apdu(mk(1'b1, INS_VERIFY, 8'h00, P2_PIN_USER, 16'd0, upin));
    issue_apdu(mk(1'b1, INS_VERIFY, 8'h00, P2_PIN_USER, 16'd1, upin));
    issue_apdu(mk(1'b1, INS_VERIFY, 8'h00, P2_PIN_SIGN, 16'd8, upin));
    issue_apdu(mk(1'b1, INS_VERIFY, 8'h00, P2_PIN_USER, 16'd6, upin));
    issue_apdu(mk(1'b1, INS_VERIFY, 8'h00, P2_PIN_SIGN, 16'd6, upin));
    issue_apdu(mk(1'b1, INS_VERIFY, 8'h00, P2_PIN_USER, 16'd0, upin));
    repeat (4) issue_apdu(mk(1'b1, INS_VERIFY, 8'h00, P2_PIN_ADMIN, 16'd15, apin));
    issue_apdu(mk(1'b1, INS_VERIFY, 8'h00, P2_PIN_ADMIN, 16'd0, apin));
    issue_apdu(mk(1'b1, INS_PUT, 8'h00, 8'h6E, 16'd4, 64'd0));
    issue_apdu(mk(1'b1, INS_SIGN, P1_SIGN, P2_SIGN, 16'd32, 64'd0));
    run_random(20);
  endtask

  // result side: random pop, compare each taken result with the oldest prediction
  always @(posedge clk_i) begin : result_check
    res_t want;
    if (rst_ni && pop && !empty) begin
      if (expected_answers.size() == 0) begin
        log_failure($sformatf("result with no request pending: status %0d retries %0d fwd %0d",
                              status_o, retries_o, forward_o));
      end else begin
        want = expected_answers.pop_front();
        if (status_o !== want.status || retries_o !== want.retries ||
            forward_o !== want.forward) begin
          log_failure($sformatf("status %0d/%0d retries %0d/%0d fwd %0d/%0d (expected/actual)",
                                want.status, status_o, want.retries, retries_o,
                                want.forward, forward_o));
        end
      end
    end
    pop <= ($urandom_range(99) >= pop_stall_pct);
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_command_paths();
    test_length_extremes();
    test_zero_pin_and_drain();
    test_slow_sender();
    test_back_to_back();
    test_lockout();
    // drain, then keep clocking so stray results would still be caught
    wait_idle();
    repeat (8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
